// ----- src/cbpm_pkg.sv -----
package cbpm_pkg;

  localparam int NUM_FRAMES = 16;
  localparam int FW = $clog2(NUM_FRAMES);

  localparam logic [2:0] OP_READ    = 3'd0;
  localparam logic [2:0] OP_ALLOC   = 3'd1;
  localparam logic [2:0] OP_UNPIN   = 3'd2;
  localparam logic [2:0] OP_DISPOSE = 3'd3;
  localparam logic [2:0] OP_FLUSH   = 3'd4;

  localparam logic [2:0] ST_OK         = 3'd0;
  localparam logic [2:0] ST_ALLPINNED  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND   = 3'd2;
  localparam logic [2:0] ST_NOTPINNED  = 3'd3;
  localparam logic [2:0] ST_PAGEPINNED = 3'd4;

  localparam logic [1:0] ACT_NONE    = 2'd0;
  localparam logic [1:0] ACT_WRITE   = 2'd1;
  localparam logic [1:0] ACT_FETCH   = 2'd2;
  localparam logic [1:0] ACT_DEALLOC = 2'd3;

  typedef struct packed {
    logic [2:0]  status;
    logic        hit;
    logic [3:0]  frame;
    logic [1:0]  action;
    logic [7:0]  action_file;
    logic [23:0] action_page;
    logic        last;
  } result_t;

endpackage

// ----- src/cbpm_out_reg.sv -----
module cbpm_out_reg
  import cbpm_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  result_t push_data,
  output logic    full,
  output logic    out_tvalid,
  input  logic    out_tready,
  output result_t out_data
);

  logic    valid_r;
  result_t data_r;

  assign full       = valid_r;
  assign out_tvalid = valid_r;
  assign out_data   = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (push) begin
      valid_r <= 1'b1;
    end else if (out_tready) begin
      valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      data_r <= push_data;
    end
  end

  // The sequencer only pushes into a slot that is empty or is read out in that cycle.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !valid_r || out_tready) else $error("result overwritten");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_tready |=> valid_r && $stable(data_r)) else $error("result lost");
  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    push |=> valid_r) else $error("pushed result not shown");

endmodule

// ----- src/clock_buffer_pool_manager.sv -----
// Buffer pool manager with clock page replacement over NUM_FRAMES frames.
// Input channel in_*: one command per transfer; tdata holds op, file_id,
// page_no and dirty_mark. The block takes one command at a time and drops
// in_tready from acceptance until the final result of that command has
// been transferred out.
// Output channel out_*: each command yields zero to NUM_FRAMES action
// results (write back, fetch, deallocate) and one final result with
// out_tlast high and the status.
// Frames are visited one per cycle, except while a write back waits for
// the output register; lookup and flush share one match/compare step.
// A lookup visits up to NUM_FRAMES frames, a clock sweep up to
// 2*NUM_FRAMES, a flush up to NUM_FRAMES.
// When the receiver stalls, the walk waits until the single output
// register is free; no result is lost or repeated.
// Reset (synchronous, active low) clears all frames and puts the clock
// hand on the last frame; the block is ready in the next cycle.
module clock_buffer_pool_manager
  import cbpm_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // op[2:0], file_id[10:3], page_no[34:11], dirty_mark[35]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // status[2:0], hit[3], frame[7:4], action[9:8],
                                  // action_file[17:10], action_page[41:18]
  output logic        out_tlast
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOOK  = 7'b0000010,
    S_SWEEP = 7'b0000100,
    S_FETCH = 7'b0001000,
    S_FLUSH = 7'b0010000,
    S_DONE  = 7'b0100000,
    S_WAIT  = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;

  logic [NUM_FRAMES-1:0] valid_r, ref_r, dirty_r;
  logic [7:0]            pin_r  [NUM_FRAMES];
  logic [7:0]            file_r [NUM_FRAMES];
  logic [23:0]           page_r [NUM_FRAMES];
  logic [FW-1:0]         hand_r;

  logic [2:0]   op_r;
  logic [7:0]   fid_r;
  logic [23:0]  pg_r;
  logic         dm_r;
  logic [FW-1:0] idx_r;
  logic [FW:0]   cnt_r;
  result_t      fin_r;

  // The sweep counter is wide enough for 2*NUM_FRAMES steps.
  logic [FW+1:0] swc_r;

  logic dealloc_done_r;

  logic    push, full;
  result_t push_data, out_data;

  cbpm_out_reg u_out (
    .clk, .rst_n, .push, .push_data, .full,
    .out_tvalid, .out_tready, .out_data
  );

  // Output packing: status, hit, frame, action, action_file, action_page
  // fill 42 bits; tdata is 48 bits wide in full.
  assign out_tdata = {6'd0, out_data.action_page, out_data.action_file, out_data.action,
                      out_data.frame, out_data.hit, out_data.status};
  assign out_tlast = out_data.last;

  assign in_tready = (state_r == S_IDLE);
  logic acc;
  assign acc = in_tvalid && in_tready;

  // Shared per-frame unit: state of the frame under idx_r.
  logic cur_match, cur_fmatch, room;
  logic [FW-1:0] idx_inc;
  assign cur_fmatch = valid_r[idx_r] && (file_r[idx_r] == fid_r);
  assign cur_match  = cur_fmatch && (page_r[idx_r] == pg_r);
  assign room       = !full || out_tready;
  assign idx_inc    = (idx_r == FW'(NUM_FRAMES-1)) ? '0 : idx_r + 1'b1;

  logic    last_frame;
  assign last_frame = (cnt_r == (FW+1)'(NUM_FRAMES-1));

  always_comb begin
    state_nxt = state_r;
    push      = 1'b0;
    push_data = '0;
    case (state_r)
      S_IDLE:  if (acc) state_nxt = S_LOOK;
      S_LOOK: begin
        if (op_r == OP_FLUSH) begin
          state_nxt = S_FLUSH;
        end else if (op_r > OP_FLUSH) begin
          state_nxt = S_DONE;
        end else if (cur_match) begin
          state_nxt = S_DONE;
        end else if (last_frame) begin
          if (op_r == OP_READ || op_r == OP_ALLOC) state_nxt = S_SWEEP;
          else state_nxt = S_DONE;
        end
      end
      S_SWEEP: begin
        if (!valid_r[idx_inc]) begin
          state_nxt = (op_r == OP_READ) ? S_FETCH : S_DONE;
        end else if (!ref_r[idx_inc] && pin_r[idx_inc] == 8'd0) begin
          if (dirty_r[idx_inc]) begin
            if (room) begin
              push = 1'b1;
              push_data.frame = 4'(idx_inc);
              push_data.action = ACT_WRITE;
              push_data.action_file = file_r[idx_inc];
              push_data.action_page = page_r[idx_inc];
              state_nxt = (op_r == OP_READ) ? S_FETCH : S_DONE;
            end
          end else begin
            state_nxt = (op_r == OP_READ) ? S_FETCH : S_DONE;
          end
        end else if (swc_r == (FW+2)'(2*NUM_FRAMES-1)) begin
          state_nxt = S_DONE;
        end
      end
      S_FETCH: if (room) begin
        push = 1'b1;
        push_data.frame = 4'(idx_r);
        push_data.action = ACT_FETCH;
        push_data.action_file = fid_r;
        push_data.action_page = pg_r;
        state_nxt = S_DONE;
      end
      S_FLUSH: begin
        if (cur_fmatch && pin_r[idx_r] != 8'd0) begin
          state_nxt = S_DONE;
        end else if (cur_fmatch && dirty_r[idx_r]) begin
          if (room) begin
            push = 1'b1;
            push_data.frame = 4'(idx_r);
            push_data.action = ACT_WRITE;
            push_data.action_file = file_r[idx_r];
            push_data.action_page = page_r[idx_r];
            if (last_frame) state_nxt = S_DONE;
          end
        end else if (last_frame) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: if (room) begin
        push = 1'b1;
        if (op_r == OP_DISPOSE && !dealloc_done_r) begin
          push_data.frame = fin_r.frame;
          push_data.action = ACT_DEALLOC;
          push_data.action_file = fid_r;
          push_data.action_page = pg_r;
        end else begin
          push_data = fin_r;
          state_nxt = S_WAIT;
        end
      end
      S_WAIT: if (!full || out_tready) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      valid_r <= '0;
      ref_r   <= '0;
      dirty_r <= '0;
      hand_r  <= FW'(NUM_FRAMES-1);
      for (int i = 0; i < NUM_FRAMES; i++) pin_r[i] <= 8'd0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        S_IDLE: if (acc) begin
          op_r  <= in_tdata[2:0];
          fid_r <= in_tdata[10:3];
          pg_r  <= in_tdata[34:11];
          dm_r  <= in_tdata[35];
          idx_r <= '0;
          cnt_r <= '0;
          fin_r <= '{status: ST_OK, hit: 1'b0, frame: '0, action: ACT_NONE,
                     action_file: '0, action_page: '0, last: 1'b1};
        end
        S_LOOK: begin
          if (op_r == OP_FLUSH || op_r > OP_FLUSH) begin
            idx_r <= '0;
            cnt_r <= '0;
          end else if (cur_match) begin
            fin_r.frame <= 4'(idx_r);
            fin_r.hit   <= 1'b1;
            if (op_r == OP_READ || op_r == OP_ALLOC) begin
              ref_r[idx_r] <= 1'b1;
              if (pin_r[idx_r] != 8'hFF) pin_r[idx_r] <= pin_r[idx_r] + 8'd1;
            end else if (op_r == OP_UNPIN) begin
              if (pin_r[idx_r] == 8'd0) begin
                fin_r.status <= ST_NOTPINNED;
              end else begin
                pin_r[idx_r] <= pin_r[idx_r] - 8'd1;
                if (dm_r) dirty_r[idx_r] <= 1'b1;
              end
            end else begin
              valid_r[idx_r] <= 1'b0;
              ref_r[idx_r]   <= 1'b0;
              dirty_r[idx_r] <= 1'b0;
              pin_r[idx_r]   <= 8'd0;
            end
          end else if (last_frame) begin
            idx_r <= hand_r;
            swc_r <= '0;
            if (op_r == OP_UNPIN) fin_r.status <= ST_NOTFOUND;
          end else begin
            idx_r <= idx_inc;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        S_SWEEP: begin
          if (!valid_r[idx_inc] ||
              (!ref_r[idx_inc] && pin_r[idx_inc] == 8'd0 &&
               (!dirty_r[idx_inc] || room))) begin
            idx_r  <= idx_inc;
            hand_r <= idx_inc;
            fin_r.frame <= 4'(idx_inc);
            valid_r[idx_inc] <= 1'b1;
            pin_r[idx_inc]   <= 8'd1;
            ref_r[idx_inc]   <= 1'b1;
            dirty_r[idx_inc] <= 1'b0;
            file_r[idx_inc]  <= fid_r;
            page_r[idx_inc]  <= pg_r;
          end else if (!(!ref_r[idx_inc] && pin_r[idx_inc] == 8'd0)) begin
            if (ref_r[idx_inc]) ref_r[idx_inc] <= 1'b0;
            idx_r <= idx_inc;
            swc_r <= swc_r + 1'b1;
            if (swc_r == (FW+2)'(2*NUM_FRAMES-1)) fin_r.status <= ST_ALLPINNED;
          end
        end
        S_FLUSH: begin
          if (cur_fmatch && pin_r[idx_r] != 8'd0) begin
            fin_r.status <= ST_PAGEPINNED;
            fin_r.frame  <= 4'(idx_r);
          end else if (!(cur_fmatch && dirty_r[idx_r]) || room) begin
            if (cur_fmatch) begin
              valid_r[idx_r] <= 1'b0;
              ref_r[idx_r]   <= 1'b0;
              dirty_r[idx_r] <= 1'b0;
            end
            idx_r <= idx_inc;
            cnt_r <= cnt_r + 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  // Dispose emits its deallocate before the final result.
  always_ff @(posedge clk) begin
    if (!rst_n) dealloc_done_r <= 1'b0;
    else if (acc) dealloc_done_r <= 1'b0;
    else if (state_r == S_DONE && push) dealloc_done_r <= 1'b1;
  end

endmodule
